[rtl/particle_pool_update_core_macros.svh]
// Assertion macros for the particle pool update core.
// Included by ppu_ctrl, the RTL file that carries concurrent assertions.
`ifndef PARTICLE_POOL_UPDATE_CORE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_CORE_MACROS_SVH

// assert that antecedent implies consequent in the same cycle
`define PPU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// assert that antecedent implies consequent in the next cycle
`define PPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ppu_pkg.sv]
// Package for the particle pool update core: types, constants, helpers.
// No dependencies.
package ppu_pkg;

   localparam int POOL_SLOTS_DEF = 64;
   localparam int OUT_LIMIT      = 64;

   localparam logic [6:0]  POOL_SIZE_RST  = 7'd64;
   localparam logic [11:0] FADE_RATE_RST  = 12'd640;
   localparam logic [7:0]  VEL_SCALE_RST  = 8'd26;
   localparam logic [14:0] SPAWN_LIFE_RST = 15'd16384;
   localparam logic signed [15:0] ALPHA_FULL = 16'sd16384;

   localparam logic [1:0] CSR_POOL_SIZE  = 2'd0;
   localparam logic [1:0] CSR_FADE_RATE  = 2'd1;
   localparam logic [1:0] CSR_VEL_SCALE  = 2'd2;
   localparam logic [1:0] CSR_SPAWN_LIFE = 2'd3;

   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SEARCH = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_SPAWN  = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_TICK   = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load_req;
      logic rd_en;
      logic spawn_wr;
      logic tick_wr;
      logic life_wr;
      logic emit;
      logic emit_last;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic slot_dead;
      logic tick_dead;
      logic out_busy;
   } stat_type;

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) r = 16'sh7fff;
      else if (v < -20'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [7:0] jitter_of(input logic [6:0] d);
      logic [6:0] c;
      logic [10:0] x;
      logic [23:0] t;
      c = (d > 7'd99) ? 7'd99 : d;
      x = {c, 4'd5};
      t = 24'(x) * 24'd6554;
      return 8'(signed'({1'b0, t[23:16]}) - 9'sd80);
   endfunction

   function automatic logic [8:0] shade_of(input logic [6:0] d);
      logic [6:0] c;
      logic [14:0] y;
      logic [28:0] t;
      c = (d > 7'd99) ? 7'd99 : d;
      y = {c, 8'd50};
      t = 29'(y) * 29'd10486;
      return 9'd128 + {1'b0, t[27:20]};
   endfunction

endpackage

[rtl/particle_pool_update_core.sv]
// Particle pool update core. A spawn request searches next-fit for a dead
// slot (life read, then check for each slot examined) and returns one
// result; a tick request walks every active slot (memory read, then
// update for each slot) and is held by stalls on the result channel. The
// slot memories hold one read and one write port each.
module particle_pool_update_core #(
   parameter int POOL_SLOTS = ppu_pkg::POOL_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [15:0]        req_tick_dt,
   input  logic signed [15:0] req_source_x,
   input  logic signed [15:0] req_source_y,
   input  logic signed [15:0] req_source_vx,
   input  logic signed [15:0] req_source_vy,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   input  logic [6:0]         req_jitter_draw,
   input  logic [6:0]         req_shade_draw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_slot,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [8:0]         rsp_shade,
   output logic signed [15:0] rsp_alpha,
   output logic               rsp_last
);

   localparam int IW = $clog2(POOL_SLOTS);

   logic [6:0]  pool_size_ff;
   logic [11:0] fade_rate_ff;
   logic [7:0]  vel_scale_ff;
   logic [14:0] spawn_life_ff;
   ppu_pkg::cmd_type  cmd;
   ppu_pkg::stat_type stat;
   logic [IW-1:0] addr;
   logic [5:0] out_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= ppu_pkg::POOL_SIZE_RST;
         fade_rate_ff  <= ppu_pkg::FADE_RATE_RST;
         vel_scale_ff  <= ppu_pkg::VEL_SCALE_RST;
         spawn_life_ff <= ppu_pkg::SPAWN_LIFE_RST;
      end else if (csr_we) begin
         case (csr_index)
            ppu_pkg::CSR_POOL_SIZE:  pool_size_ff  <= csr_wdata[6:0];
            ppu_pkg::CSR_FADE_RATE:  fade_rate_ff  <= csr_wdata[11:0];
            ppu_pkg::CSR_VEL_SCALE:  vel_scale_ff  <= csr_wdata[7:0];
            ppu_pkg::CSR_SPAWN_LIFE: spawn_life_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ppu_ctrl #(.POOL_SLOTS(POOL_SLOTS), .IW(IW)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_op,
      .pool_size(pool_size_ff), .stat, .cmd, .addr, .out_slot
   );

   ppu_datapath #(.POOL_SLOTS(POOL_SLOTS), .IW(IW)) u_dp (
      .clock, .reset, .cmd, .addr, .out_slot, .stat,
      .fade_rate(fade_rate_ff), .vel_scale(vel_scale_ff), .spawn_life(spawn_life_ff),
      .req_tick_dt, .req_source_x, .req_source_y, .req_source_vx, .req_source_vy,
      .req_offset_x, .req_offset_y, .req_jitter_draw, .req_shade_draw,
      .rsp_valid, .rsp_ready, .rsp_slot, .rsp_pos_x, .rsp_pos_y,
      .rsp_shade, .rsp_alpha, .rsp_last
   );

endmodule

[rtl/ppu_datapath.sv]
// Datapath of the particle pool update core: slot memories, arithmetic,
// result register. Depends on ppu_pkg.
module ppu_datapath #(
   parameter int POOL_SLOTS = ppu_pkg::POOL_SLOTS_DEF,
   parameter int IW = $clog2(POOL_SLOTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ppu_pkg::cmd_type     cmd,
   input  logic [IW-1:0]        addr,
   input  logic [5:0]           out_slot,
   output ppu_pkg::stat_type    stat,
   input  logic [11:0]          fade_rate,
   input  logic [7:0]           vel_scale,
   input  logic [14:0]          spawn_life,
   input  logic [15:0]          req_tick_dt,
   input  logic signed [15:0]   req_source_x,
   input  logic signed [15:0]   req_source_y,
   input  logic signed [15:0]   req_source_vx,
   input  logic signed [15:0]   req_source_vy,
   input  logic signed [15:0]   req_offset_x,
   input  logic signed [15:0]   req_offset_y,
   input  logic [6:0]           req_jitter_draw,
   input  logic [6:0]           req_shade_draw,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_slot,
   output logic signed [15:0]   rsp_pos_x,
   output logic signed [15:0]   rsp_pos_y,
   output logic [8:0]           rsp_shade,
   output logic signed [15:0]   rsp_alpha,
   output logic                 rsp_last
);

   logic signed [15:0] mem_x [POOL_SLOTS];
   logic signed [15:0] mem_y [POOL_SLOTS];
   logic signed [15:0] mem_vx [POOL_SLOTS];
   logic signed [15:0] mem_vy [POOL_SLOTS];
   logic signed [15:0] mem_alpha [POOL_SLOTS];
   logic [8:0]         mem_shade [POOL_SLOTS];
   logic signed [15:0] mem_life [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] valid_ff;

   logic [15:0] dt_ff;
   logic signed [15:0] px_ff, py_ff, pvx_ff, pvy_ff, sx_ff, sy_ff;
   logic signed [7:0]  jit_ff;
   logic [8:0]  shd_ff, rd_shade_ff;
   logic signed [15:0] rd_x_ff, rd_y_ff, rd_vx_ff, rd_vy_ff, rd_a_ff, rd_life_ff;
   logic signed [15:0] nx_ff, ny_ff, na_ff;
   logic [8:0]  ns_ff;

   logic signed [15:0] life_new;
   logic signed [16:0] dt14;
   logic [27:0] fade_prod;
   logic signed [18:0] fade;
   logic signed [32:0] mx, my;
   logic signed [19:0] nx, ny, na;
   logic signed [23:0] vxm, vym;
   logic signed [19:0] vxs, vys, ssx, ssy;

   logic out_v_ff;
   logic [5:0] o_slot_ff;
   logic signed [15:0] o_x_ff, o_y_ff, o_a_ff;
   logic [8:0] o_s_ff;
   logic o_last_ff;

   assign dt14 = 17'(({1'b0, dt_ff} + 17'd2) >> 2);
   assign life_new = ppu_pkg::sat16(20'(rd_life_ff) - 20'(dt14));
   assign stat.slot_dead = (rd_life_ff <= 16'sd0);
   assign stat.tick_dead = (life_new <= 16'sd0);
   assign stat.out_busy = out_v_ff && !rsp_ready;

   assign fade_prod = 28'(fade_rate) * 28'(dt_ff) + 28'd512;
   assign fade = {1'b0, fade_prod[27:10]};
   assign mx = 33'(rd_vx_ff) * 33'(signed'({1'b0, dt_ff})) + 33'sd32768;
   assign my = 33'(rd_vy_ff) * 33'(signed'({1'b0, dt_ff})) + 33'sd32768;
   assign nx = 20'(rd_x_ff) - 20'(mx >>> 16);
   assign ny = 20'(rd_y_ff) - 20'(my >>> 16);
   assign na = 20'(rd_a_ff) - 20'(fade);

   assign vxm = 24'(pvx_ff) * 24'(signed'({1'b0, vel_scale})) + 24'sd128;
   assign vym = 24'(pvy_ff) * 24'(signed'({1'b0, vel_scale})) + 24'sd128;
   assign vxs = 20'(vxm >>> 8);
   assign vys = 20'(vym >>> 8);
   assign ssx = 20'(px_ff) + 20'(sx_ff) + 20'(jit_ff);
   assign ssy = 20'(py_ff) + 20'(sy_ff) + 20'(jit_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         dt_ff  <= req_tick_dt;
         px_ff  <= req_source_x;
         py_ff  <= req_source_y;
         sx_ff  <= req_offset_x;
         sy_ff  <= req_offset_y;
         pvx_ff <= req_source_vx;
         pvy_ff <= req_source_vy;
         jit_ff <= ppu_pkg::jitter_of(req_jitter_draw);
         shd_ff <= ppu_pkg::shade_of(req_shade_draw);
      end
      if (cmd.rd_en) begin
         rd_x_ff  <= mem_x[addr];
         rd_y_ff  <= mem_y[addr];
         rd_vx_ff <= mem_vx[addr];
         rd_vy_ff <= mem_vy[addr];
         rd_a_ff  <= mem_alpha[addr];
         rd_shade_ff <= mem_shade[addr];
         rd_life_ff <= valid_ff[addr] ? mem_life[addr] : 16'sd0;
      end
      if (cmd.spawn_wr) begin
         mem_x[addr]     <= ppu_pkg::sat16(ssx);
         mem_y[addr]     <= ppu_pkg::sat16(ssy);
         mem_vx[addr]    <= ppu_pkg::sat16(vxs);
         mem_vy[addr]    <= ppu_pkg::sat16(vys);
         mem_shade[addr] <= shd_ff;
         mem_alpha[addr] <= ppu_pkg::ALPHA_FULL;
         mem_life[addr]  <= 16'(spawn_life);
         nx_ff <= ppu_pkg::sat16(ssx);
         ny_ff <= ppu_pkg::sat16(ssy);
         na_ff <= ppu_pkg::ALPHA_FULL;
         ns_ff <= shd_ff;
      end
      if (cmd.life_wr) begin
         mem_life[addr] <= life_new;
      end
      if (cmd.tick_wr) begin
         mem_x[addr]     <= ppu_pkg::sat16(nx);
         mem_y[addr]     <= ppu_pkg::sat16(ny);
         mem_alpha[addr] <= ppu_pkg::sat16(na);
         nx_ff <= ppu_pkg::sat16(nx);
         ny_ff <= ppu_pkg::sat16(ny);
         na_ff <= ppu_pkg::sat16(na);
         ns_ff <= rd_shade_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.spawn_wr || cmd.life_wr) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_slot_ff <= out_slot;
         o_x_ff    <= nx_ff;
         o_y_ff    <= ny_ff;
         o_a_ff    <= na_ff;
         o_s_ff    <= ns_ff;
         o_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_slot  = o_slot_ff;
   assign rsp_pos_x = o_x_ff;
   assign rsp_pos_y = o_y_ff;
   assign rsp_shade = o_s_ff;
   assign rsp_alpha = o_a_ff;
   assign rsp_last  = o_last_ff;

endmodule

[rtl/ppu_ctrl.sv]
// Controller of the particle pool update core: spawn search and tick walk.
// Depends on ppu_pkg and the assertion macro header.
`include "particle_pool_update_core_macros.svh"
module ppu_ctrl #(
   parameter int POOL_SLOTS = ppu_pkg::POOL_SLOTS_DEF,
   parameter int IW = $clog2(POOL_SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [6:0]        pool_size,
   input  ppu_pkg::stat_type stat,
   output ppu_pkg::cmd_type  cmd,
   output logic [IW-1:0]     addr,
   output logic [5:0]        out_slot
);

   localparam int LIM = (POOL_SLOTS < ppu_pkg::OUT_LIMIT) ? POOL_SLOTS : ppu_pkg::OUT_LIMIT;
   localparam logic [6:0] LIM7 = 7'(LIM);

   ppu_pkg::state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in, start_ff, start_in, srch_ff, srch_in;
   logic [6:0] cnt_ff, cnt_in, n;
   logic have_ff, have_in;
   logic [IW-1:0] pend_ff, pend_in;
   logic [IW-1:0] nxt;

   assign n = (pool_size == 7'd0) ? 7'd1 : ((pool_size > LIM7) ? LIM7 : pool_size);
   assign nxt = (7'(idx_ff) + 7'd1 >= n) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      start_in = start_ff;
      srch_in = srch_ff;
      cnt_in = cnt_ff;
      have_in = have_ff;
      pend_in = pend_ff;
      cmd = '0;
      addr = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         ppu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               have_in = 1'b0;
               cnt_in = '0;
               if (req_op == ppu_pkg::OP_SPAWN) begin
                  idx_in = (7'(start_ff) < n) ? start_ff : '0;
                  state_in = ppu_pkg::ST_SEARCH;
               end else begin
                  idx_in = '0;
                  state_in = ppu_pkg::ST_READ;
               end
            end
         end
         ppu_pkg::ST_SEARCH: begin
            cmd.rd_en = 1'b1;
            state_in = ppu_pkg::ST_CHECK;
         end
         ppu_pkg::ST_CHECK: begin
            if (stat.slot_dead) begin
               srch_in = idx_ff;
               state_in = ppu_pkg::ST_SPAWN;
            end else if (cnt_ff + 7'd1 >= n) begin
               srch_in = '0;
               state_in = ppu_pkg::ST_SPAWN;
            end else begin
               idx_in = nxt;
               cnt_in = cnt_ff + 7'd1;
               state_in = ppu_pkg::ST_SEARCH;
            end
         end
         ppu_pkg::ST_SPAWN: begin
            addr = srch_ff;
            cmd.spawn_wr = 1'b1;
            start_in = srch_ff;
            pend_in = srch_ff;
            have_in = 1'b1;
            state_in = ppu_pkg::ST_EMIT;
         end
         ppu_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in = ppu_pkg::ST_TICK;
         end
         ppu_pkg::ST_TICK: begin
            if (stat.tick_dead || !stat.out_busy) begin
               cmd.life_wr = 1'b1;
               if (!stat.tick_dead) begin
                  if (have_ff) cmd.emit = 1'b1;
                  cmd.tick_wr = 1'b1;
                  pend_in = idx_ff;
                  have_in = 1'b1;
               end
               if (7'(idx_ff) + 7'd1 >= n) state_in = ppu_pkg::ST_EMIT;
               else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ppu_pkg::ST_READ;
               end
            end
         end
         ppu_pkg::ST_EMIT: begin
            if (!stat.out_busy) begin
               if (have_ff) begin
                  cmd.emit = 1'b1;
                  cmd.emit_last = 1'b1;
               end
               have_in = 1'b0;
               state_in = ppu_pkg::ST_IDLE;
            end
         end
         default: state_in = ppu_pkg::ST_IDLE;
      endcase
   end

   assign out_slot = 6'(pend_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppu_pkg::ST_IDLE;
         idx_ff <= '0;
         start_ff <= '0;
         srch_ff <= '0;
         cnt_ff <= '0;
         have_ff <= 1'b0;
         pend_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         start_ff <= start_in;
         srch_ff <= srch_in;
         cnt_ff <= cnt_in;
         have_ff <= have_in;
         pend_ff <= pend_in;
      end
   end

   `PPU_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `PPU_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !stat.out_busy, "emit over busy output")
   `PPU_ASSERT_NEXT(a_spawn_emit, clock, reset, cmd.spawn_wr, state_ff == ppu_pkg::ST_EMIT,
      "spawn not followed by emit")

endmodule

[test/particle_pool_update_core_test.sv]
// Self-checking testbench for particle_pool_update_core: spawn and tick requests
// checked against an in-bench pool predictor. Depends on ppu_pkg and the core.
module particle_pool_update_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0]         slot;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [8:0]         shade;
      logic signed [15:0] alpha;
      logic               last;
   } particle_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = ppu_pkg::CSR_POOL_SIZE;
   logic [14:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = ppu_pkg::OP_SPAWN;
   logic [15:0] req_tick_dt = '0;
   logic signed [15:0] req_source_x = '0, req_source_y = '0;
   logic signed [15:0] req_source_vx = '0, req_source_vy = '0;
   logic signed [15:0] req_offset_x = '0, req_offset_y = '0;
   logic [6:0] req_jitter_draw = '0, req_shade_draw = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_slot;
   logic signed [15:0] rsp_pos_x, rsp_pos_y, rsp_alpha;
   logic [8:0] rsp_shade;
   logic rsp_last;

   particle_pool_update_core u_dut (.*);

   always #2 clock = ~clock;

   // pool shadow
   logic [6:0]  pool_size_q;
   logic [11:0] fade_rate_q;
   logic [7:0]  vel_scale_q;
   logic [14:0] spawn_life_q;
   logic signed [15:0] px [64], py [64], pvx [64], pvy [64], plife [64], palpha [64];
   logic [8:0] pshade [64];
   int search_ptr;

   particle_rsp_type expected_rsps [$];
   int errors = 0;
   bit idle_enable = 1'b1;

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic longint scale_dt(longint v, longint m);
      longint p;
      p = v * m + 32768;
      return p >>> 16;
   endfunction

   function automatic int active_slots();
      int n;
      n = pool_size_q;
      if (n < 1) n = 1;
      if (n > 64) n = 64;
      return n;
   endfunction

   function automatic particle_rsp_type slot_rsp(int s, logic last);
      particle_rsp_type r;
      r.slot = 6'(s);
      r.pos_x = px[s];
      r.pos_y = py[s];
      r.shade = pshade[s];
      r.alpha = palpha[s];
      r.last = last;
      return r;
   endfunction

   task automatic predict_pool_update(logic op, logic [15:0] dt,
         logic signed [15:0] sx, sy, svx, svy, ox, oy, logic [6:0] jd_in, sd_in);
      int n, s, jd, sd, jit, start;
      longint dt14, fade;
      particle_rsp_type rs [$];
      n = active_slots();
      if (op == ppu_pkg::OP_SPAWN) begin
         jd = (jd_in > 99) ? 99 : jd_in;
         sd = (sd_in > 99) ? 99 : sd_in;
         jit = (16 * jd + 5) / 10 - 80;
         start = (search_ptr < n) ? search_ptr : 0;
         s = -1;
         for (int i = start; i < n && s < 0; i++) if (plife[i] <= 0) s = i;
         for (int i = 0; i < start && s < 0; i++) if (plife[i] <= 0) s = i;
         if (s < 0) s = 0;
         search_ptr = s;
         px[s] = clamp16(longint'(sx) + ox + jit);
         py[s] = clamp16(longint'(sy) + oy + jit);
         pvx[s] = clamp16((longint'(svx) * longint'(vel_scale_q) + 128) >>> 8);
         pvy[s] = clamp16((longint'(svy) * longint'(vel_scale_q) + 128) >>> 8);
         pshade[s] = 9'(128 + (256 * sd + 50) / 100);
         palpha[s] = ppu_pkg::ALPHA_FULL;
         plife[s] = 16'(spawn_life_q);
         expected_rsps.push_back(slot_rsp(s, 1'b1));
      end else begin
         dt14 = (longint'(dt) + 2) >> 2;
         fade = (longint'(fade_rate_q) * dt + 512) >> 10;
         for (int i = 0; i < n; i++) begin
            plife[i] = clamp16(longint'(plife[i]) - dt14);
            if (plife[i] > 0) begin
               px[i] = clamp16(longint'(px[i]) - scale_dt(pvx[i], dt));
               py[i] = clamp16(longint'(py[i]) - scale_dt(pvy[i], dt));
               palpha[i] = clamp16(longint'(palpha[i]) - fade);
               rs.push_back(slot_rsp(i, 1'b0));
            end
         end
         if (rs.size() > 0) rs[rs.size() - 1].last = 1'b1;
         foreach (rs[k]) expected_rsps.push_back(rs[k]);
      end
   endtask

   task automatic idle_burst();
      if (idle_enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 13)) @(negedge clock);
   endtask

   task automatic send_request(logic op, logic [15:0] dt,
         logic signed [15:0] sx, sy, svx, svy, ox, oy, logic [6:0] jd, sd);
      idle_burst();
      req_valid <= 1'b1;
      req_op <= op;
      req_tick_dt <= dt;
      req_source_x <= sx;
      req_source_y <= sy;
      req_source_vx <= svx;
      req_source_vy <= svy;
      req_offset_x <= ox;
      req_offset_y <= oy;
      req_jitter_draw <= jd;
      req_shade_draw <= sd;
      do @(posedge clock); while (!req_ready);
      predict_pool_update(op, dt, sx, sy, svx, svy, ox, oy, jd, sd);
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic spawn_small(int jd, int sd);
      send_request(ppu_pkg::OP_SPAWN, 16'd0,
         16'($urandom_range(0, 4000)) - 16'sd2000,
         16'($urandom_range(0, 4000)) - 16'sd2000, 16'($urandom), 16'($urandom),
         16'($urandom_range(0, 200)) - 16'sd100, 16'($urandom_range(0, 200)) - 16'sd100,
         7'(jd), 7'(sd));
   endtask

   task automatic tick(int dt);
      send_request(ppu_pkg::OP_TICK, 16'(dt), '0, '0, '0, '0, '0, '0, '0, '0);
   endtask

   task automatic drain();
      while (expected_rsps.size() > 0) @(negedge clock);
      repeat (140) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, int val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 15'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ppu_pkg::CSR_POOL_SIZE:  pool_size_q = 7'(val);
         ppu_pkg::CSR_FADE_RATE:  fade_rate_q = 12'(val);
         ppu_pkg::CSR_VEL_SCALE:  vel_scale_q = 8'(val);
         ppu_pkg::CSR_SPAWN_LIFE: spawn_life_q = 15'(val);
         default: ;
      endcase
   endtask

   task automatic test_directed();
      tick(65535);
      send_request(ppu_pkg::OP_SPAWN, 16'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
         16'sh7fff, 16'sh8000, 7'd99, 7'd99);
      send_request(ppu_pkg::OP_SPAWN, 16'd0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
         16'sh8000, 16'sh7fff, 7'd0, 7'd0);
      send_request(ppu_pkg::OP_SPAWN, 16'd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100,
         16'sd0, 16'sd0, 7'd127, 7'd127);
      spawn_small(50, 50);
      tick(0);
      tick(1);
      tick(3000);
      tick(65535);
      tick(65535);
   endtask

   task automatic test_small_pool();
      write_csr(ppu_pkg::CSR_POOL_SIZE, 0);
      spawn_small(10, 20);
      spawn_small(30, 40);
      tick(100);
      write_csr(ppu_pkg::CSR_POOL_SIZE, 3);
      repeat (5) spawn_small($urandom_range(0, 127), $urandom_range(0, 127));
      tick(500);
      drain();
      write_csr(ppu_pkg::CSR_POOL_SIZE, 2);
      spawn_small(5, 5);
      tick(65535);
      tick(65535);
      drain();
   endtask

   task automatic test_config_extremes();
      write_csr(ppu_pkg::CSR_POOL_SIZE, 127);
      write_csr(ppu_pkg::CSR_FADE_RATE, 4095);
      write_csr(ppu_pkg::CSR_VEL_SCALE, 255);
      write_csr(ppu_pkg::CSR_SPAWN_LIFE, 32767);
      repeat (4) spawn_small($urandom_range(0, 127), $urandom_range(0, 127));
      tick(20000);
      drain();
      write_csr(ppu_pkg::CSR_FADE_RATE, 0);
      write_csr(ppu_pkg::CSR_VEL_SCALE, 0);
      write_csr(ppu_pkg::CSR_SPAWN_LIFE, 0);
      spawn_small(1, 1);
      tick(4);
      drain();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count - 30) begin
            drain();
            idle_enable = 1'b0;
         end
         if ($urandom_range(0, 3) == 0)
            tick($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000));
         else if ($urandom_range(0, 7) == 0)
            send_request(ppu_pkg::OP_SPAWN, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               7'($urandom), 7'($urandom));
         else
            spawn_small($urandom_range(0, 127), $urandom_range(0, 127));
      end
   endtask

   always @(negedge clock)
      rsp_ready <= (!idle_enable || $urandom_range(0, 5) != 0) ? 1'b1
         : ($urandom_range(0, 1) == 0 ? 1'b0 : rsp_ready);

   always @(posedge clock) begin
      particle_rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_slot, rsp_pos_x, rsp_pos_y, rsp_shade, rsp_alpha, rsp_last};
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response %p", $time, got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               $display("%0t mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   initial begin
      pool_size_q = ppu_pkg::POOL_SIZE_RST;
      fade_rate_q = ppu_pkg::FADE_RATE_RST;
      vel_scale_q = ppu_pkg::VEL_SCALE_RST;
      spawn_life_q = ppu_pkg::SPAWN_LIFE_RST;
      search_ptr = 0;
      for (int i = 0; i < 64; i++) begin
         px[i] = 0; py[i] = 0; pvx[i] = 0; pvy[i] = 0;
         plife[i] = 0; palpha[i] = 0; pshade[i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (140) @(negedge clock);
      test_directed();
      drain();
      test_small_pool();
      test_config_extremes();
      write_csr(ppu_pkg::CSR_POOL_SIZE, 64);
      write_csr(ppu_pkg::CSR_FADE_RATE, 640);
      write_csr(ppu_pkg::CSR_VEL_SCALE, 26);
      write_csr(ppu_pkg::CSR_SPAWN_LIFE, 16384);
      write_csr(ppu_pkg::CSR_POOL_SIZE, 20);
      test_random(50);
      drain();
      write_csr(ppu_pkg::CSR_POOL_SIZE, 64);
      idle_enable = 1'b1;
      test_random(60);
      drain();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
